FILE: sv/fprd_pkg.sv
// fprd_pkg: shared types, constants and helpers of the radix digit formatter.
// Used by fprd_ctrl, fprd_datapath, the top level and the checker.
// No dependencies.
package fprd_pkg;

  localparam int VALUE_W     = 64;
  localparam int RADIX_W     = 5;
  localparam int CHAR_W      = 7;
  localparam int DIGIT_W     = 4;
  localparam int INT_DEPTH   = 32;
  localparam int IIDX_W      = 5;
  localparam int ICNT_W      = 6;
  localparam int DIV_STEPS   = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET   = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_F     = 7'h46;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INT_DIV,
    ST_FRAC,
    ST_EMIT_SIGN,
    ST_EMIT_INT,
    ST_EMIT_DOT,
    ST_EMIT_FRAC
  } state_t;

  typedef enum logic [1:0] {
    SEL_MINUS,
    SEL_INT,
    SEL_DOT,
    SEL_FRAC
  } char_sel_t;

  typedef struct packed {
    logic      load;
    logic      div_step;
    logic      frac_step;
    logic      emit;
    char_sel_t sel;
    logic      is_last;
  } cmd_t;

  typedef struct packed {
    logic neg;
    logic div_digit_done;
    logic int_more;
    logic frac_more;
    logic int_one;
    logic frac_any;
    logic frac_end;
    logic out_free;
  } stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

FILE: sv/fprd_ctrl.sv
// fprd_ctrl: sequencer of the radix digit formatter.
// Issues fprd_pkg::cmd_t commands to fprd_datapath and follows its status.
// Depends on fprd_pkg.
module fprd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fprd_pkg::stat_t  stat,
  output fprd_pkg::cmd_t   cmd
);

  fprd_pkg::state_t state;
  fprd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fprd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.div_step  = 1'b0;
    cmd.frac_step = 1'b0;
    cmd.emit      = 1'b0;
    cmd.sel       = fprd_pkg::SEL_INT;
    cmd.is_last   = 1'b0;
    case (state)
      fprd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = fprd_pkg::ST_INT_DIV;
        end
      end
      fprd_pkg::ST_INT_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_digit_done && !stat.int_more) begin
          state_next = fprd_pkg::ST_FRAC;
        end
      end
      fprd_pkg::ST_FRAC: begin
        if (stat.frac_more) begin
          cmd.frac_step = 1'b1;
        end else if (stat.neg) begin
          state_next = fprd_pkg::ST_EMIT_SIGN;
        end else begin
          state_next = fprd_pkg::ST_EMIT_INT;
        end
      end
      fprd_pkg::ST_EMIT_SIGN: begin
        cmd.sel = fprd_pkg::SEL_MINUS;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = fprd_pkg::ST_EMIT_INT;
        end
      end
      fprd_pkg::ST_EMIT_INT: begin
        cmd.sel     = fprd_pkg::SEL_INT;
        cmd.is_last = stat.int_one && !stat.frac_any;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.int_one) begin
            state_next = stat.frac_any ? fprd_pkg::ST_EMIT_DOT : fprd_pkg::ST_IDLE;
          end
        end
      end
      fprd_pkg::ST_EMIT_DOT: begin
        cmd.sel = fprd_pkg::SEL_DOT;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = fprd_pkg::ST_EMIT_FRAC;
        end
      end
      fprd_pkg::ST_EMIT_FRAC: begin
        cmd.sel     = fprd_pkg::SEL_FRAC;
        cmd.is_last = stat.frac_end;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.frac_end) begin
            state_next = fprd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = fprd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/fprd_datapath.sv
// fprd_datapath: radix register, digit divider, fraction multiplier,
// digit stores and output register of the radix digit formatter.
// Depends on fprd_pkg; driven by fprd_ctrl.
module fprd_datapath #(
  parameter int FRAC_BITS   = 32,
  parameter int FRAC_DIGITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [fprd_pkg::RADIX_W-1:0]        cfg_wr_data,
  input  logic signed [fprd_pkg::VALUE_W-1:0] value,
  input  logic                                out_ready,
  input  fprd_pkg::cmd_t                      cmd,
  output fprd_pkg::stat_t                     stat,
  output logic                                out_valid,
  output logic [fprd_pkg::CHAR_W-1:0]         char_code,
  output logic                                last
);

  localparam int IPW     = fprd_pkg::VALUE_W - FRAC_BITS;
  localparam int DIV_W   = ((IPW + fprd_pkg::DIV_STEPS - 1) / fprd_pkg::DIV_STEPS)
                           * fprd_pkg::DIV_STEPS;
  localparam int DIV_CYC = DIV_W / fprd_pkg::DIV_STEPS;
  localparam int STEP_W  = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int FCNT_W  = $clog2(FRAC_DIGITS + 1);
  localparam int FIDX_W  = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
  localparam int PROD_W  = FRAC_BITS + fprd_pkg::RADIX_W;

  logic [fprd_pkg::RADIX_W-1:0] radix;
  logic [fprd_pkg::RADIX_W-1:0] base;
  logic                         neg;
  logic [DIV_W-1:0]             ip;
  logic [fprd_pkg::RADIX_W-1:0] rem;
  logic [STEP_W-1:0]            step;
  logic [fprd_pkg::ICNT_W-1:0]  int_cnt;
  logic [FRAC_BITS-1:0]         fp;
  logic [FCNT_W-1:0]            gen;
  logic [FCNT_W-1:0]            keep;
  logic [FCNT_W-1:0]            fidx;

  logic [fprd_pkg::DIGIT_W-1:0] int_store  [fprd_pkg::INT_DEPTH];
  logic [fprd_pkg::DIGIT_W-1:0] frac_store [FRAC_DIGITS];

  logic [fprd_pkg::VALUE_W-1:0] val_u;
  logic [fprd_pkg::VALUE_W-1:0] mag;
  logic [DIV_W-1:0]             quo;
  logic [fprd_pkg::RADIX_W-1:0] rem_next;
  logic [PROD_W-1:0]            prod;
  logic [fprd_pkg::DIGIT_W-1:0] frac_digit;
  logic [fprd_pkg::IIDX_W-1:0]  int_rd_idx;

  assign val_u      = value;
  assign mag        = val_u[fprd_pkg::VALUE_W-1] ? (~val_u + 1'b1) : val_u;
  assign prod       = PROD_W'(fp) * PROD_W'(base);
  assign frac_digit = prod[FRAC_BITS +: fprd_pkg::DIGIT_W];
  assign int_rd_idx = fprd_pkg::IIDX_W'(int_cnt - 1'b1);

  // Long division by the radix, several quotient bits per cycle.
  always_comb begin
    quo      = ip;
    rem_next = rem;
    for (int k = 0; k < fprd_pkg::DIV_STEPS; k++) begin
      rem_next = {rem_next[fprd_pkg::RADIX_W-2:0], quo[DIV_W-1]};
      quo      = {quo[DIV_W-2:0], 1'b0};
      if (rem_next >= base) begin
        rem_next = rem_next - base;
        quo[0]   = 1'b1;
      end
    end
  end

  always_comb begin
    stat.neg            = neg;
    stat.div_digit_done = (step == STEP_W'(DIV_CYC - 1));
    stat.int_more       = (quo != '0) && (int_cnt < fprd_pkg::ICNT_W'(fprd_pkg::INT_DEPTH - 1));
    stat.frac_more      = (fp != '0) && (gen < FCNT_W'(FRAC_DIGITS));
    stat.int_one        = (int_cnt == fprd_pkg::ICNT_W'(1));
    stat.frac_any       = (keep != '0);
    stat.frac_end       = (fidx == FCNT_W'(keep - 1'b1));
    stat.out_free       = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= fprd_pkg::RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= val_u[fprd_pkg::VALUE_W-1];
      base    <= (radix inside {[2:16]}) ? radix : fprd_pkg::RADIX_DEFAULT;
      ip      <= DIV_W'(mag[fprd_pkg::VALUE_W-1:FRAC_BITS]);
      fp      <= mag[FRAC_BITS-1:0];
      rem     <= '0;
      step    <= '0;
      int_cnt <= '0;
      gen     <= '0;
      keep    <= '0;
      fidx    <= '0;
    end else begin
      if (cmd.div_step) begin
        ip <= quo;
        if (stat.div_digit_done) begin
          int_store[int_cnt[fprd_pkg::IIDX_W-1:0]] <= rem_next[fprd_pkg::DIGIT_W-1:0];
          int_cnt <= int_cnt + 1'b1;
          rem     <= '0;
          step    <= '0;
        end else begin
          rem  <= rem_next;
          step <= step + 1'b1;
        end
      end
      if (cmd.frac_step) begin
        frac_store[gen[FIDX_W-1:0]] <= frac_digit;
        fp  <= prod[FRAC_BITS-1:0];
        gen <= gen + 1'b1;
        // track the last nonzero digit so trailing zeros drop out
        if (frac_digit != '0) begin
          keep <= gen + 1'b1;
        end
      end
      if (cmd.emit && cmd.sel == fprd_pkg::SEL_INT) begin
        int_cnt <= int_cnt - 1'b1;
      end
      if (cmd.emit && cmd.sel == fprd_pkg::SEL_FRAC) begin
        fidx <= fidx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last <= cmd.is_last;
      case (cmd.sel)
        fprd_pkg::SEL_MINUS: char_code <= fprd_pkg::CHAR_MINUS;
        fprd_pkg::SEL_INT:   char_code <= fprd_pkg::digit_char(int_store[int_rd_idx]);
        fprd_pkg::SEL_DOT:   char_code <= fprd_pkg::CHAR_DOT;
        fprd_pkg::SEL_FRAC:  char_code <= fprd_pkg::digit_char(frac_store[fidx[FIDX_W-1:0]]);
        default:             char_code <= fprd_pkg::CHAR_ZERO;
      endcase
    end
  end

endmodule

FILE: sv/fixed_point_to_radix_digits.sv
// Sequence: after a transaction on the input, the shared divider produces the
// integer digits (at least one digit, up to 32), the fraction multiplier then
// produces the fraction digits (up to FRAC_DIGITS), the controller leaves fraction
// work, then one character per cycle while the output is not stalled by out_ready.
// Throughput: one value at a time; the next value is taken as soon as the last
// character enters the output register. Reset: rst is synchronous, radix = 10.
//
// Top level of the radix digit formatter: fprd_ctrl sequences, fprd_datapath
// computes and holds the digits. Depends on fprd_pkg.
module fixed_point_to_radix_digits #(
  parameter int FRAC_BITS   = 32,
  parameter int FRAC_DIGITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration: radix, 2..16 (anything else acts as 10)
  input  logic                                cfg_wr_en,
  input  logic [fprd_pkg::RADIX_W-1:0]        cfg_wr_data,
  // input channel: one signed fixed-point value per transaction
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [fprd_pkg::VALUE_W-1:0] value,
  // output channel: one ASCII character per transaction
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fprd_pkg::CHAR_W-1:0]         char_code,
  output logic                                last
);

  fprd_pkg::cmd_t  cmd;
  fprd_pkg::stat_t stat;

  // Controller: divide out integer digits, then generate fraction digits, then walk
  // sign if negative, integer digits (most significant first), dot and fraction if any.
  fprd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: holds the radix, the digit stores and the output register, so
  // a finished character can wait for out_ready while a new value is taken.
  fprd_datapath #(
    .FRAC_BITS   (FRAC_BITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .value       (value),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .char_code   (char_code),
    .last        (last)
  );

endmodule

FILE: sv/fprd_checker.sv
// fprd_checker: port-level assertions for the radix digit formatter, and the
// bind that attaches them to fixed_point_to_radix_digits.
// Depends on fprd_pkg.
module fprd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [fprd_pkg::CHAR_W-1:0] char_code,
  input logic                        last
);

  // hold a stalled character
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last))
    else $error("stalled output character changed");

  // one value at a time: drop ready after a transaction on the input
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted during conversion");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == fprd_pkg::CHAR_MINUS) || (char_code == fprd_pkg::CHAR_DOT) ||
                  (char_code >= fprd_pkg::CHAR_ZERO && char_code <= fprd_pkg::CHAR_NINE) ||
                  (char_code >= fprd_pkg::CHAR_A && char_code <= fprd_pkg::CHAR_F))
    else $error("illegal character code");

  a_sign_dot_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((char_code == fprd_pkg::CHAR_MINUS) || (char_code == fprd_pkg::CHAR_DOT))
    |-> !last)
    else $error("sign or dot marked as final character");

  // ready comes back only once the final character sits in the output register
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(in_ready) |-> out_valid && last)
    else $error("input ready before final character was loaded");

endmodule

bind fixed_point_to_radix_digits fprd_checker u_fprd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .char_code (char_code),
  .last      (last)
);
